### src/kse_pkg.sv
// ----------------------------------------------------------------------------
// Key sort engine package
// Shared constants, types and control encodings for the key sort engine.
// ----------------------------------------------------------------------------
package kse_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_BITS_DEF  = 32;
	localparam int DATA_W        = 32;
	localparam int MODE_W        = 2;

	localparam int MODE_DESC_BIT   = 0;
	localparam int MODE_SIGNED_BIT = 1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_DRAIN
	} kse_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_SORT,
		OP_SHIFT_OUT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic                phase;
		logic [MODE_W-1:0]   mode;
	} cell_ctrl_t;

endpackage

### src/kse_cell.sv
// ----------------------------------------------------------------------------
// Key sort cell
// One slot of the sorting chain: shifts keys in and out and performs an
// odd-even compare-exchange with one of its neighbors.
// ----------------------------------------------------------------------------
module kse_cell import kse_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic                left_valid,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic                right_valid,
	output logic [KEY_BITS-1:0] key_q,
	output logic                valid_q
);

	localparam logic [KEY_BITS-1:0] SIGN_MASK = KEY_BITS'(1) << (KEY_BITS - 1);
	localparam logic                ODD_SLOT  = 1'((CELL_IDX % 2));

	logic                is_lower;
	logic [KEY_BITS-1:0] flip_mask;
	logic [KEY_BITS-1:0] low_key;
	logic [KEY_BITS-1:0] high_key;
	logic                pair_valid;
	logic                swap;
	logic [KEY_BITS-1:0] key_d;
	logic                valid_d;

	always_comb begin
		is_lower  = (ctrl.phase == ODD_SLOT);
		flip_mask = (ctrl.mode[MODE_SIGNED_BIT] ? SIGN_MASK : '0) ^
			(ctrl.mode[MODE_DESC_BIT] ? '1 : '0);
		if (is_lower) begin
			low_key    = key_q;
			high_key   = right_key;
			pair_valid = valid_q && right_valid;
		end else begin
			low_key    = left_key;
			high_key   = key_q;
			pair_valid = valid_q && left_valid;
		end
		swap = pair_valid && ((low_key ^ flip_mask) > (high_key ^ flip_mask));

		key_d   = key_q;
		valid_d = valid_q;
		case (ctrl.op)
			OP_SHIFT_IN: begin
				key_d   = left_key;
				valid_d = (CELL_IDX == 0) ? 1'b1 : left_valid;
			end
			OP_SHIFT_OUT: begin
				key_d   = right_key;
				valid_d = right_valid;
			end
			OP_SORT: begin
				if (swap) begin
					key_d = is_lower ? right_key : left_key;
				end
			end
			default: begin
				key_d   = key_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

### src/kse_ctrl.sv
// ----------------------------------------------------------------------------
// Key sort controller
// Sequences loading, the odd-even transposition passes and draining of the
// cell chain, and holds the compare mode register and the drop flag.
// ----------------------------------------------------------------------------
module kse_ctrl import kse_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [MODE_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              chain_full,
	input  logic              head_valid,
	input  logic              next_valid,
	input  logic              out_free,
	output logic              load_out,
	output logic              drop_q,
	output cell_ctrl_t        ctrl
);

	localparam int PASS_W = $clog2(MAX_ITEMS);

	kse_state_t        state_q;
	kse_state_t        state_d;
	logic [PASS_W-1:0] pass_q;
	logic [MODE_W-1:0] mode_q;
	logic              drop_set;
	logic              drop_clr;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		load_out   = 1'b0;
		drop_set   = 1'b0;
		drop_clr   = 1'b0;
		ctrl.op    = OP_HOLD;
		ctrl.phase = pass_q[0];
		ctrl.mode  = mode_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (chain_full) begin
						drop_set = 1'b1;
					end else begin
						ctrl.op = OP_SHIFT_IN;
					end
					if (in_last) begin
						state_d = ST_SORT;
					end
				end
			end
			ST_SORT: begin
				ctrl.op = OP_SORT;
				if (pass_q == PASS_W'(MAX_ITEMS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free && head_valid) begin
					ctrl.op  = OP_SHIFT_OUT;
					load_out = 1'b1;
					if (!next_valid) begin
						drop_clr = 1'b1;
						state_d  = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pass_q  <= '0;
			mode_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SORT) begin
				pass_q <= pass_q + PASS_W'(1);
			end else begin
				pass_q <= '0;
			end
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (drop_set) begin
				drop_q <= 1'b1;
			end else if (drop_clr) begin
				drop_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> head_valid)
		else $error("Drain state entered with an empty chain.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT && state_d == ST_DRAIN) |-> (pass_q == PASS_W'(MAX_ITEMS - 1)))
		else $error("Sorting ended before all passes were run.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !in_ready)
		else $error("Input accepted outside the load state.");
`endif

endmodule

### src/key_sort_engine_top.sv
// ----------------------------------------------------------------------------
// Key sort engine
// Collects a batch of keys and returns them in the order set by the compare
// mode register.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle, while a batch is loading, into a chain of
// MAX_ITEMS cells. The item with tlast closes the batch; the chain then runs
// MAX_ITEMS odd-even transposition passes, one per cycle, and shifts the
// sorted keys out one per cycle through the output register as the sink takes
// them. The next batch is taken once the final key has reached the output
// register. Keys that arrive when the chain is full are dropped, and tuser is
// set on every result of that batch. No clearing pass is needed after reset.
module key_sort_engine_top import kse_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MODE_W-1:0] cfg_data,   // compare_mode
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,    // key_value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,    // sorted_key
	output logic              m_tlast,
	output logic              m_tuser     // overflowed
);

	logic [KEY_BITS-1:0]  key_vec [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] valid_vec;
	logic [KEY_BITS-1:0]  key_in;
	cell_ctrl_t           ctrl;
	logic                 load_out;
	logic                 drop_q;
	logic                 out_free;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_key_q;
	logic                 out_last_q;
	logic                 out_drop_q;

	assign cfg_ready = 1'b1;
	assign key_in    = KEY_BITS'(s_tdata);
	assign out_free  = !out_valid_q || m_tready;

	kse_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.chain_full(valid_vec[MAX_ITEMS-1]),
		.head_valid(valid_vec[0]),
		.next_valid(valid_vec[1]),
		.out_free  (out_free),
		.load_out  (load_out),
		.drop_q    (drop_q),
		.ctrl      (ctrl)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [KEY_BITS-1:0] left_key;
		logic                left_valid;
		logic [KEY_BITS-1:0] right_key;
		logic                right_valid;

		if (i == 0) begin : g_first
			assign left_key   = key_in;
			assign left_valid = 1'b0;
		end else begin : g_mid_l
			assign left_key   = key_vec[i-1];
			assign left_valid = valid_vec[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right_key   = '0;
			assign right_valid = 1'b0;
		end else begin : g_mid_r
			assign right_key   = key_vec[i+1];
			assign right_valid = valid_vec[i+1];
		end

		kse_cell #(
			.KEY_BITS(KEY_BITS),
			.CELL_IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_key   (left_key),
			.left_valid (left_valid),
			.right_key  (right_key),
			.right_valid(right_valid),
			.key_q      (key_vec[i]),
			.valid_q    (valid_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_key_q  <= DATA_W'(key_vec[0]);
			out_last_q <= !valid_vec[1];
			out_drop_q <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + (MAX_ITEMS + 1)'(1)))
		else $error("Occupied cells are not contiguous from the head.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_SORT) |=> $stable(valid_vec))
		else $error("A sort pass changed the cell occupancy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !valid_vec[1]) |=> (valid_vec == '0))
		else $error("Chain not empty after the final item of a batch.");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key sort engine testbench
// Sends batches of keys through the stream input and checks that each batch
// comes back sorted under the compare mode in force, with the final key
// marked and the drop flag set on batches that overran the key store.
// Directed batches cover the key extremes in every compare mode and a
// single-key batch. Random batches follow, mostly short, a few filling the
// store exactly and a few overrunning it. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import kse_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNS_ASC  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNS_DESC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SGN_ASC  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SGN_DESC = 2'd3;
	localparam int STORE_DEPTH  = MAX_ITEMS_DEF;
	localparam int RANDOM_ITEMS = 460;

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic              last;
		logic              dropped;
	} sorted_key_t;

	class sort_scoreboard;
		logic [DATA_W-1:0] batch_keys[$];
		bit                batch_dropped;
		logic [MODE_W-1:0] mode;
		sorted_key_t       expected[$];
		int                errors;

		function new();
			batch_dropped = 1'b0;
			mode          = MODE_UNS_ASC;
			errors        = 0;
		endfunction

		function logic [DATA_W-1:0] rank(logic [DATA_W-1:0] k);
			logic [DATA_W-1:0] v;
			v = k;
			if (mode[MODE_SIGNED_BIT])
				v = v ^ {1'b1, {(DATA_W-1){1'b0}}};
			if (mode[MODE_DESC_BIT])
				v = ~v;
			return v;
		endfunction

		function void note_key(logic [DATA_W-1:0] key, logic last);
			logic [DATA_W-1:0] cur;
			sorted_key_t       res;
			int                i;
			int                j;
			if (batch_keys.size() < STORE_DEPTH)
				batch_keys.push_back(key);
			else
				batch_dropped = 1'b1;
			if (last) begin
				for (i = 1; i < batch_keys.size(); i++) begin
					cur = batch_keys[i];
					j = i;
					while (j > 0 && rank(batch_keys[j-1]) > rank(cur)) begin
						batch_keys[j] = batch_keys[j-1];
						j--;
					end
					batch_keys[j] = cur;
				end
				for (i = 0; i < batch_keys.size(); i++) begin
					res.key     = batch_keys[i];
					res.last    = (i == batch_keys.size() - 1);
					res.dropped = batch_dropped;
					expected.push_back(res);
				end
				batch_keys.delete();
				batch_dropped = 1'b0;
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [DATA_W-1:0] key, logic last, logic dropped);
			sorted_key_t exp_res;
			if (expected.size() == 0) begin
				report($sformatf("unexpected item key=%h", key));
			end else begin
				exp_res = expected.pop_front();
				if (key !== exp_res.key)
					report($sformatf("key %h, want %h", key, exp_res.key));
				if (last !== exp_res.last)
					report($sformatf("tlast %b, want %b", last, exp_res.last));
				if (dropped !== exp_res.dropped)
					report($sformatf("tuser %b, want %b", dropped, exp_res.dropped));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [MODE_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	sort_scoreboard    sb = new();
	int                items_sent = 0;
	int                rx_wait = 0;
	bit                tx_quiet = 1'b0;
	bit                rx_quiet = 1'b0;
	logic [DATA_W-1:0] prev_key = '0;

	key_sort_engine_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait  <= rx_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tlast, m_tuser);
			if (m_tlast)
				rx_quiet = ($urandom_range(0, 2) == 0);
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
		end
	end

	task automatic send_key(logic [DATA_W-1:0] key, logic last);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_key(key, last);
		items_sent++;
	endtask

	task automatic wait_drained(int tail);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] mode);
		wait_drained(8);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		sb.mode = mode;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_extremes();
		send_key(32'hFFFF_FFFF, 1'b0);
		send_key(32'h0000_0000, 1'b0);
		send_key(32'h8000_0000, 1'b0);
		send_key(32'h7FFF_FFFF, 1'b0);
		send_key(32'h0000_0001, 1'b1);
	endtask

	function automatic logic [DATA_W-1:0] pick_key();
		logic [DATA_W-1:0] k;
		case ($urandom_range(0, 5))
			0: k = $urandom_range(0, 15);
			1: k = 32'h7FFF_FFF0 + $urandom_range(0, 31);
			2: begin
				case ($urandom_range(0, 3))
					0: k = 32'h0000_0000;
					1: k = 32'hFFFF_FFFF;
					2: k = 32'h8000_0000;
					default: k = 32'h7FFF_FFFF;
				endcase
			end
			3: k = prev_key;
			default: k = $urandom;
		endcase
		prev_key = k;
		return k;
	endfunction

	initial begin
		int batch_len;
		int i;
		int random_base;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_extremes();
		send_key(32'hA5A5_A5A5, 1'b1);
		write_mode(MODE_UNS_DESC);
		send_extremes();
		write_mode(MODE_SGN_ASC);
		send_extremes();
		write_mode(MODE_SGN_DESC);
		send_extremes();
		write_mode(MODE_UNS_ASC);

		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_mode(MODE_W'($urandom_range(0, 3)));
			tx_quiet = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 19))
				0: batch_len = STORE_DEPTH;
				1: batch_len = STORE_DEPTH + $urandom_range(1, 6);
				2: batch_len = $urandom_range(40, STORE_DEPTH - 1);
				default: batch_len = $urandom_range(1, 12);
			endcase
			for (i = 0; i < batch_len; i++)
				send_key(pick_key(), i == batch_len - 1);
		end

		wait_drained(200);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
